// ===== hdl/gsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsl_pkg
// shared types and codes of the grid spot legalizer
// ----------------------------------------------------------------------------
package gsl_pkg;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_FIXED = 2'd1;
	localparam logic [1:0] CMD_PLACE = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_DUP    = 2'd1;
	localparam logic [1:0] STAT_NOSPOT = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	localparam logic [2:0] REG_IGNORE_CORE = 3'd0;
	localparam logic [2:0] REG_CORE_X_LOW  = 3'd1;
	localparam logic [2:0] REG_CORE_Y_LOW  = 3'd2;
	localparam logic [2:0] REG_CORE_X_HIGH = 3'd3;
	localparam logic [2:0] REG_CORE_Y_HIGH = 3'd4;
	localparam logic [2:0] REG_STEP_LIMIT  = 3'd5;

	typedef struct packed {
		logic              ignore_core;
		logic signed [31:0] core_x_low;
		logic signed [31:0] core_y_low;
		logic signed [31:0] core_x_high;
		logic signed [31:0] core_y_high;
		logic        [7:0]  step_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CAND,
		ST_CORE,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/gsl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsl_in_if / gsl_out_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface gsl_in_if;
	logic              valid;
	logic              ready;
	logic        [1:0]  cmd;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, output cmd, output pos_x, output pos_y, input ready);
	modport sink   (input valid, input cmd, input pos_x, input pos_y, output ready);
endinterface

interface gsl_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] placed_x;
	logic signed [31:0] placed_y;
	logic        [1:0]  status;
	logic              moved;

	modport source (output valid, output placed_x, output placed_y, output status,
		output moved, input ready);
	modport sink   (input valid, input placed_x, input placed_y, input status,
		input moved, output ready);
endinterface

// ===== hdl/gsl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsl_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module gsl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/gsl_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsl_regs
// apb configuration registers: core rectangle, search bound, core bypass
// ----------------------------------------------------------------------------
module gsl_regs import gsl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic       wr_fire;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ignore_core <= 1'b0;
			cfg_q.core_x_low  <= 32'sd0;
			cfg_q.core_y_low  <= 32'sd0;
			cfg_q.core_x_high <= 32'sh7fffffff;
			cfg_q.core_y_high <= 32'sh7fffffff;
			cfg_q.step_limit  <= 8'd65;
		end else if (wr_fire) begin
			unique case (reg_idx)
				REG_IGNORE_CORE: cfg_q.ignore_core <= pwdata[0];
				REG_CORE_X_LOW:  cfg_q.core_x_low  <= pwdata;
				REG_CORE_Y_LOW:  cfg_q.core_y_low  <= pwdata;
				REG_CORE_X_HIGH: cfg_q.core_x_high <= pwdata;
				REG_CORE_Y_HIGH: cfg_q.core_y_high <= pwdata;
				REG_STEP_LIMIT:  cfg_q.step_limit  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IGNORE_CORE: prdata = {31'd0, cfg_q.ignore_core};
			REG_CORE_X_LOW:  prdata = cfg_q.core_x_low;
			REG_CORE_Y_LOW:  prdata = cfg_q.core_y_low;
			REG_CORE_X_HIGH: prdata = cfg_q.core_x_high;
			REG_CORE_Y_HIGH: prdata = cfg_q.core_y_high;
			REG_STEP_LIMIT:  prdata = {24'd0, cfg_q.step_limit};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== hdl/gsl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsl_seq
// command sequencer: table sweep, candidate generation and core check
// ----------------------------------------------------------------------------
module gsl_seq import gsl_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	gsl_in_if.sink    in_ch,
	gsl_out_if.source out_ch
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int CB = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;

	state_t state_q, state_next;

	logic        [CW-1:0] count_q;
	logic        [CW-1:0] idx_q;
	logic                 rd_pend_s1;
	logic        [1:0]    cmd_q;
	logic signed [CB-1:0] x_q, y_q;
	logic        [PW-1:0] target_q;
	logic                 search_q;
	logic        [7:0]    d_q;
	logic        [1:0]    k_q;
	logic signed [CB:0]   cand_q;
	logic signed [CB-1:0] res_x_q, res_y_q;
	logic        [1:0]    res_stat_q;
	logic                 res_moved_q;

	logic                 out_valid_q;
	logic signed [31:0]   out_x_q, out_y_q;
	logic        [1:0]    out_stat_q;
	logic                 out_moved_q;

	logic                 in_fire, out_fire, out_load;
	logic signed [CB-1:0] in_x, in_y;
	logic                 full;
	logic                 rd_en, wr_en;
	logic        [PW-1:0] rd_data;
	logic                 scan_hit, scan_end, scan_miss;
	logic signed [CB:0]   cand_base, cand_sum, cand_delta;
	logic signed [CB-1:0] cx, cy;
	logic signed [31:0]   cx32, cy32;
	logic                 range_ok, core_ok, cand_ok;
	logic                 step_over;

	assign in_x     = in_ch.pos_x[CB-1:0];
	assign in_y     = in_ch.pos_y[CB-1:0];
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_valid_q && out_ch.ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
	assign full     = (count_q == CW'(MAX_POINTS));

	// table sweep compare
	assign scan_hit  = rd_pend_s1 && (rd_data == target_q);
	assign scan_end  = scan_hit || (!rd_pend_s1 && (idx_q == count_q));
	assign scan_miss = scan_end && !scan_hit;

	// candidate adder
	assign cand_base  = k_q[1] ? (CB+1)'(y_q) : (CB+1)'(x_q);
	assign cand_delta = (CB+1)'(d_q);
	assign cand_sum   = k_q[0] ? (cand_base - cand_delta) : (cand_base + cand_delta);
	assign step_over  = (d_q >= cfg.step_limit);

	// range and core compare
	assign range_ok = (cand_q[CB] == cand_q[CB-1]);
	assign cx       = k_q[1] ? x_q : cand_q[CB-1:0];
	assign cy       = k_q[1] ? cand_q[CB-1:0] : y_q;
	assign cx32     = 32'(cx);
	assign cy32     = 32'(cy);
	assign core_ok  = (cx32 >= cfg.core_x_low) && (cx32 <= cfg.core_x_high) &&
		(cy32 >= cfg.core_y_low) && (cy32 <= cfg.core_y_high);
	assign cand_ok  = range_ok && (cfg.ignore_core || core_ok);

	gsl_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (target_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					unique case (in_ch.cmd)
						CMD_FIXED: state_next = ST_SCAN;
						CMD_PLACE: state_next = full ? ST_DONE : ST_SCAN;
						default:   state_next = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (cmd_q == CMD_PLACE && scan_hit) begin
						state_next = ST_CAND;
					end else begin
						state_next = ST_DONE;
					end
				end
			end
			ST_CAND: state_next = step_over ? ST_DONE : ST_CORE;
			ST_CORE: state_next = cand_ok ? ST_SCAN : ST_CAND;
			ST_DONE: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		rd_en       = (state_q == ST_SCAN) && !scan_end && (idx_q < count_q);
		wr_en       = (state_q == ST_SCAN) && scan_miss && !(cmd_q == CMD_FIXED && full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_next;
			rd_pend_s1 <= rd_en;
			if (state_q != ST_SCAN) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (in_fire && in_ch.cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd_q       <= in_ch.cmd;
					x_q         <= in_x;
					y_q         <= in_y;
					target_q    <= {in_x, in_y};
					res_x_q     <= in_x;
					res_y_q     <= in_y;
					res_moved_q <= 1'b0;
					search_q    <= 1'b0;
					res_stat_q  <= (in_ch.cmd == CMD_PLACE && full) ? STAT_FULL : STAT_OK;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					if (cmd_q == CMD_FIXED) begin
						res_stat_q <= STAT_DUP;
					end else if (!search_q) begin
						search_q <= 1'b1;
						d_q      <= 8'd1;
						k_q      <= 2'd0;
					end else begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							d_q <= d_q + 8'd1;
						end
					end
				end else if (scan_miss) begin
					if (cmd_q == CMD_FIXED && full) begin
						res_stat_q <= STAT_FULL;
					end else if (search_q) begin
						res_x_q     <= target_q[PW-1:CB];
						res_y_q     <= target_q[CB-1:0];
						res_moved_q <= 1'b1;
					end
				end
			end
			ST_CAND: begin
				if (step_over) begin
					res_stat_q <= STAT_NOSPOT;
				end else begin
					cand_q <= cand_sum;
				end
			end
			ST_CORE: begin
				if (cand_ok) begin
					target_q <= {cx, cy};
				end else begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						d_q <= d_q + 8'd1;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_x_q     <= 32'(res_x_q);
			out_y_q     <= 32'(res_y_q);
			out_stat_q  <= res_stat_q;
			out_moved_q <= res_moved_q;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.placed_x = out_x_q;
	assign out_ch.placed_y = out_y_q;
	assign out_ch.status   = out_stat_q;
	assign out_ch.moved    = out_moved_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("fill count beyond table depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("table write while full");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.cmd == CMD_CLEAR) |=> (count_q == '0))
		else $error("clear request left entries");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_moved_q) |-> (out_stat_q == STAT_OK))
		else $error("moved result without ok status");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_SCAN))
		else $error("table read outside sweep");

endmodule

// ===== hdl/grid_spot_legalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_spot_legalizer
// occupied grid point table with collision-free placement search
// ----------------------------------------------------------------------------
// Each request is handled alone; the block takes no new request until the
// current one has its result in the output register. Clear and unused
// commands, and a place on a full table, go straight to the done state with
// no table sweep. A lookup sweeps the occupied table through the single
// read port of the table ram, one entry per cycle, then makes the last
// compare on the registered read data and closes the sweep. When the
// requested point is taken, every search candidate passes the adder state
// and the core compare state, and goes through a table sweep if it passes
// the range and core checks. A result held by a stalled output channel
// keeps the block in its done state. The table is emptied through its fill
// count, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module grid_spot_legalizer import gsl_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	gsl_in_if.sink               in_ch,
	gsl_out_if.source            out_ch
);

	cfg_t cfg;

	gsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gsl_seq #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ===== sim/gsl_placement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsl_placement_checker
// watches the request and result channels of the grid spot legalizer and the
// register writes on its configuration port, keeps its own occupancy grid,
// works out the result of every accepted request and compares it field by
// field with the results that come out, in order
// ----------------------------------------------------------------------------
module gsl_placement_checker import gsl_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	input  logic                 pready,
	gsl_in_if                    in_mon,
	gsl_out_if                   out_mon,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic signed [31:0] placed_x;
		logic signed [31:0] placed_y;
		logic        [1:0]  status;
		logic               moved;
	} spot_t;

	logic [63:0] grid_pts [MAX_POINTS];
	int          grid_cnt;
	spot_t       placements_due [$];

	bit     ign_core;
	longint x_lo, y_lo, x_hi, y_hi;
	int     step_lim;

	function automatic bit grid_has(logic [63:0] p);
		for (int i = 0; i < grid_cnt; i++)
			if (grid_pts[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void grid_add(logic [63:0] p);
		if (grid_cnt < MAX_POINTS) begin
			grid_pts[grid_cnt] = p;
			grid_cnt++;
		end
	endfunction

	function automatic spot_t legalize_spot(logic [1:0] cmd, logic signed [31:0] x,
		logic signed [31:0] y);
		spot_t       r;
		longint      cx, cy, lim;
		logic [63:0] c;
		bit          found;
		r.placed_x = x;
		r.placed_y = y;
		r.status   = STAT_OK;
		r.moved    = 1'b0;
		lim        = longint'(1) <<< 31;
		found      = 1'b0;
		case (cmd)
			CMD_CLEAR: grid_cnt = 0;
			CMD_FIXED: begin
				if (grid_has({x, y}))
					r.status = STAT_DUP;
				else if (grid_cnt >= MAX_POINTS)
					r.status = STAT_FULL;
				else
					grid_add({x, y});
			end
			CMD_PLACE: begin
				if (grid_cnt >= MAX_POINTS) begin
					r.status = STAT_FULL;
				end else if (!grid_has({x, y})) begin
					grid_add({x, y});
				end else begin
					// outward search: +x, -x, +y, -y at each distance
					for (int d = 1; d < step_lim && !found; d++)
						for (int k = 0; k < 4 && !found; k++) begin
							cx = longint'(x) + (k == 0 ? d : (k == 1 ? -d : 0));
							cy = longint'(y) + (k == 2 ? d : (k == 3 ? -d : 0));
							c  = {cx[31:0], cy[31:0]};
							if (cx >= -lim && cx < lim && cy >= -lim && cy < lim
								&& !grid_has(c)
								&& (ign_core || (cx >= x_lo && cx <= x_hi
								&& cy >= y_lo && cy <= y_hi))) begin
								grid_add(c);
								r.placed_x = cx[31:0];
								r.placed_y = cy[31:0];
								r.moved    = 1'b1;
								found      = 1'b1;
							end
						end
					if (!found)
						r.status = STAT_NOSPOT;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		spot_t due;
		if (!arst_n) begin
			grid_cnt = 0;
			ign_core = 1'b0;
			x_lo     = 0;
			y_lo     = 0;
			x_hi     = 2147483647;
			y_hi     = 2147483647;
			step_lim = 65;
			placements_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_IGNORE_CORE: ign_core = pwdata[0];
					REG_CORE_X_LOW:  x_lo = longint'($signed(pwdata));
					REG_CORE_Y_LOW:  y_lo = longint'($signed(pwdata));
					REG_CORE_X_HIGH: x_hi = longint'($signed(pwdata));
					REG_CORE_Y_HIGH: y_hi = longint'($signed(pwdata));
					REG_STEP_LIMIT:  step_lim = int'(pwdata[7:0]);
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (placements_due.size() == 0) begin
					$display("%0t: unexpected result (%0d, %0d) status %0d moved %0d", $time,
						$signed(out_mon.placed_x), $signed(out_mon.placed_y),
						out_mon.status, out_mon.moved);
					mismatches++;
				end else begin
					due = placements_due.pop_front();
					if (due.placed_x !== out_mon.placed_x) begin
						$display("%0t: placed_x expected %0d got %0d", $time,
							$signed(due.placed_x), $signed(out_mon.placed_x));
						mismatches++;
					end
					if (due.placed_y !== out_mon.placed_y) begin
						$display("%0t: placed_y expected %0d got %0d", $time,
							$signed(due.placed_y), $signed(out_mon.placed_y));
						mismatches++;
					end
					if (due.status !== out_mon.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							due.status, out_mon.status);
						mismatches++;
					end
					if (due.moved !== out_mon.moved) begin
						$display("%0t: moved expected %0d got %0d", $time,
							due.moved, out_mon.moved);
						mismatches++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				placements_due = {placements_due,
					legalize_spot(in_mon.cmd, in_mon.pos_x, in_mon.pos_y)};
			outstanding = placements_due.size();
		end
	end

endmodule

// ===== sim/grid_spot_legalizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_spot_legalizer_tb
// drives the grid spot legalizer with a directed opening (duplicates, search
// at the coordinate limits, core exclusion, step limits, empty core) and then
// random batches of mostly fixed and place requests in small windows that collide
// and fill the grid, under changing register settings and random stalls on
// both channels; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module grid_spot_legalizer_tb;
	import gsl_pkg::*;

	localparam int ITEMS       = 1750;
	localparam int CALM_ITEMS  = 250;
	localparam int QUIET_LIMIT = 200000;

	localparam logic [31:0] C_MAX = 32'h7fffffff;
	localparam logic [31:0] C_MIN = 32'h80000000;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	int mismatches;
	int outstanding;
	int items_sent;
	int req_count;
	int quiet;
	bit idle_en;

	gsl_in_if  req_ch ();
	gsl_out_if res_ch ();

	grid_spot_legalizer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (req_ch),
		.out_ch  (res_ch)
	);

	gsl_placement_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.in_mon      (req_ch),
		.out_mon     (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side stalls, with calm stretches
	initial begin : res_drive
		int hold;
		int ticks;
		hold         = 0;
		ticks        = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			ticks++;
			if (hold > 0) begin
				res_ch.ready = 1'b0;
				hold--;
			end else if (idle_en && (ticks / 256) % 4 != 0 && $urandom_range(0, 7) == 0) begin
				res_ch.ready = 1'b0;
				hold         = $urandom_range(0, 18);
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_req(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y);
		@(negedge clk);
		if (idle_en && (req_count / 40) % 3 != 0 && $urandom_range(0, 2) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd   = cmd;
		req_ch.pos_x = x;
		req_ch.pos_y = y;
		do @(posedge clk); while (!req_ch.ready);
		req_count++;
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic write_layout(input bit ign, input logic [31:0] xl, input logic [31:0] yl,
		input logic [31:0] xh, input logic [31:0] yh, input logic [7:0] steps);
		drain();
		cfg_write(REG_IGNORE_CORE, {31'd0, ign});
		cfg_write(REG_CORE_X_LOW, xl);
		cfg_write(REG_CORE_Y_LOW, yl);
		cfg_write(REG_CORE_X_HIGH, xh);
		cfg_write(REG_CORE_Y_HIGH, yh);
		cfg_write(REG_STEP_LIMIT, {24'd0, steps});
	endtask

	initial begin : stimulus
		logic [31:0] bx, by, px, py;
		int          w;
		int          pick;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_CLEAR;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		items_sent   = 0;
		req_count    = 0;
		idle_en      = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: core is the positive quadrant, search up to 64
		send_req(CMD_NONE, 32'd123, -32'sd456);
		send_req(CMD_CLEAR, 32'hffffffff, 32'd0);
		send_req(CMD_FIXED, 32'd0, 32'd0);
		send_req(CMD_FIXED, 32'd0, 32'd0);
		send_req(CMD_PLACE, 32'd0, 32'd0);
		send_req(CMD_PLACE, 32'd0, 32'd0);
		send_req(CMD_PLACE, 32'd5, 32'd5);
		send_req(CMD_PLACE, -32'sd10, -32'sd10);
		send_req(CMD_PLACE, -32'sd10, -32'sd10);
		send_req(CMD_PLACE, C_MAX, 32'd5);
		send_req(CMD_PLACE, C_MAX, 32'd5);
		send_req(CMD_FIXED, C_MIN, C_MIN);
		send_req(CMD_PLACE, C_MIN, C_MIN);

		write_layout(1'b1, C_MIN, C_MIN, C_MAX, C_MAX, 8'd65);
		send_req(CMD_PLACE, C_MIN, C_MIN);
		send_req(CMD_PLACE, C_MIN, C_MIN);
		send_req(CMD_PLACE, C_MAX, 32'd5);

		write_layout(1'b1, C_MIN, C_MIN, C_MAX, C_MAX, 8'd1);
		send_req(CMD_PLACE, 32'd0, 32'd0);
		write_layout(1'b1, C_MIN, C_MIN, C_MAX, C_MAX, 8'd0);
		send_req(CMD_PLACE, 32'd5, 32'd5);

		// empty core rectangle
		write_layout(1'b0, 32'd10, 32'd0, -32'sd10, C_MAX, 8'd129);
		send_req(CMD_PLACE, 32'd5, 32'd5);
		send_req(CMD_CLEAR, C_MAX, C_MIN);

		while (items_sent < ITEMS) begin
			idle_en = items_sent < ITEMS - CALM_ITEMS;
			w       = $urandom_range(1, 8);
			case ($urandom_range(0, 3))
				0: begin
					bx = $urandom_range(0, 1000);
					by = $urandom_range(0, 1000);
				end
				1: begin
					bx = C_MAX - $urandom_range(0, 6);
					by = $urandom_range(0, 50);
				end
				2: begin
					bx = C_MIN + $urandom_range(0, 6);
					by = C_MIN + $urandom_range(0, 6);
				end
				default: begin
					bx = $urandom;
					by = $urandom;
				end
			endcase
			case ($urandom_range(0, 5))
				0: write_layout(1'b0, 32'd0, 32'd0, C_MAX, C_MAX, 8'd65);
				1: write_layout(1'b1, $urandom, $urandom, $urandom, $urandom,
					8'($urandom_range(1, 129)));
				2: write_layout(1'b0, bx - 2, by - 2, bx + w + 1, by + w + 1,
					8'($urandom_range(1, 129)));
				3: write_layout(1'b0, bx + 5, by, bx - 5, by + 10, 8'($urandom_range(1, 20)));
				4: write_layout(1'($urandom_range(0, 1)), C_MIN, C_MIN, C_MAX, C_MAX,
					8'($urandom_range(0, 2)));
				default: write_layout(1'($urandom_range(0, 1)), C_MIN, C_MIN, C_MAX, C_MAX,
					8'd129);
			endcase
			send_req(CMD_CLEAR, $urandom, $urandom);
			repeat ($urandom_range(20, 120)) begin
				pick = $urandom_range(0, 99);
				px   = bx + $urandom_range(0, w - 1);
				py   = by + $urandom_range(0, w - 1);
				if (pick < 10)
					send_req(2'($urandom_range(0, 3)), $urandom, $urandom);
				else if (pick < 13)
					send_req(CMD_NONE, px, py);
				else if (pick < 17)
					send_req(CMD_CLEAR, px, py);
				else if (pick < 50)
					send_req(CMD_FIXED, px, py);
				else
					send_req(CMD_PLACE, px, py);
			end
		end

		drain();
		repeat (100) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
